// File: hw/rtl/khpg_pkg.sv
// Package: shared types, constants and SipHash round functions for the peer group hasher.
`timescale 1ns / 1ps

package khpg_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned MSG_WORDS     = 4;
  localparam int unsigned MSG_BYTES     = 32;
  localparam int unsigned ABSORB_BLOCKS = MSG_WORDS + 1;
  localparam int unsigned ABSORB_STAGES = ABSORB_BLOCKS * 4;
  localparam int unsigned FINAL_STAGES  = 8;
  localparam int unsigned NUM_STAGES    = ABSORB_STAGES + FINAL_STAGES;
  localparam int unsigned GROUP_W       = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned MSEL_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] WIDE_TWEAK = 64'h00000000000000ee;
  localparam logic [WORD_W-1:0] LEN_WORD   = {8'(MSG_BYTES), 56'h0};
  localparam logic [MSEL_W-1:0] MSEL_LEN   = MSEL_W'(MSG_WORDS);

  typedef logic [3:0][WORD_W-1:0]           sip_state_t;
  typedef logic [MSG_WORDS-1:0][WORD_W-1:0] msg_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
  } key_t;

  typedef struct packed {
    logic              pre;
    logic              post;
    logic              tweak;
    logic              half_b;
    logic [MSEL_W-1:0] msel;
  } stage_ctl_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned r);
    return (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic sip_state_t half_a(input sip_state_t v);
    sip_state_t o;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s2;
    s0   = v[0] + v[1];
    s2   = v[2] + v[3];
    o[1] = rotl(v[1], 13) ^ s0;
    o[0] = rotl(s0, 32);
    o[3] = rotl(v[3], 16) ^ s2;
    o[2] = s2;
    return o;
  endfunction

  function automatic sip_state_t half_b(input sip_state_t v);
    sip_state_t o;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s2;
    s0   = v[0] + v[3];
    s2   = v[2] + v[1];
    o[3] = rotl(v[3], 21) ^ s0;
    o[0] = s0;
    o[1] = rotl(v[1], 17) ^ s2;
    o[2] = rotl(s2, 32);
    return o;
  endfunction

  function automatic sip_state_t init_state(input key_t k);
    sip_state_t v;
    v[0] = k.k0 ^ IV0;
    v[1] = k.k1 ^ IV1 ^ WIDE_TWEAK;
    v[2] = k.k0 ^ IV2;
    v[3] = k.k1 ^ IV3;
    return v;
  endfunction

  function automatic stage_ctl_t stage_ctl(input int unsigned s);
    stage_ctl_t c;
    logic [1:0] ph;
    logic       absorb;
    ph       = s[1:0];
    absorb   = (s < ABSORB_STAGES);
    c.half_b = s[0];
    c.pre    = absorb && (ph == 2'd0);
    c.post   = absorb && (ph == 2'd3);
    c.tweak  = (s == ABSORB_STAGES - 1);
    c.msel   = absorb ? MSEL_W'(s >> 2) : MSEL_LEN;
    return c;
  endfunction

endpackage

// File: hw/rtl/khpg_cfg.sv
// Key register file written through the configuration channel.
`timescale 1ns / 1ps

module khpg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [khpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khpg_pkg::WORD_W-1:0]    cfg_data,
  output khpg_pkg::key_t                 key
);

  khpg_pkg::key_t key_r;
  khpg_pkg::key_t key_nxt;

  assign cfg_ready = 1'b1;
  assign key       = key_r;

  always_comb begin
    key_nxt = key_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        khpg_pkg::REG_KEY_LOW:  key_nxt.k0 = cfg_data;
        khpg_pkg::REG_KEY_HIGH: key_nxt.k1 = cfg_data;
        default:                key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

endmodule

// File: hw/rtl/khpg_stage.sv
// One pipeline stage: a SipRound half with optional message and tweak injection.
`timescale 1ns / 1ps

module khpg_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  khpg_pkg::stage_ctl_t ctl,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  khpg_pkg::sip_state_t in_v,
  input  khpg_pkg::msg_t       in_msg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output khpg_pkg::sip_state_t out_v,
  output khpg_pkg::msg_t       out_msg
);

  logic                 valid_r;
  logic                 valid_nxt;
  khpg_pkg::sip_state_t v_r;
  khpg_pkg::sip_state_t v_nxt;
  khpg_pkg::msg_t       msg_r;
  logic [khpg_pkg::WORD_W-1:0] m;
  khpg_pkg::sip_state_t x;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_v     = v_r;
  assign out_msg   = msg_r;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    m = (ctl.msel == khpg_pkg::MSEL_LEN) ? khpg_pkg::LEN_WORD : in_msg[ctl.msel[1:0]];
    x = in_v;
    if (ctl.pre) begin
      x[3] = x[3] ^ m;
    end
    v_nxt = ctl.half_b ? khpg_pkg::half_b(x) : khpg_pkg::half_a(x);
    if (ctl.post) begin
      v_nxt[0] = v_nxt[0] ^ m;
    end
    if (ctl.tweak) begin
      v_nxt[2] = v_nxt[2] ^ khpg_pkg::WIDE_TWEAK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      v_r   <= v_nxt;
      msg_r <= in_msg;
    end
  end

endmodule

// File: hw/rtl/keyed_hash_peer_group.sv
// Keyed SipHash-2-4 peer group selector over a 256-bit identity.
// Pipeline: 28 half-round stages followed by an output register.
// Accepts one transaction per cycle while in_stall is low; each stage holds one half SipRound (two 64-bit adds).
// Stalls back up stage by stage, so empty stages still fill while the output is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and clears both key registers to zero.
`timescale 1ns / 1ps

module keyed_hash_peer_group (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [khpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [khpg_pkg::WORD_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [khpg_pkg::WORD_W-1:0]     in_ident_word0,
  input  logic [khpg_pkg::WORD_W-1:0]     in_ident_word1,
  input  logic [khpg_pkg::WORD_W-1:0]     in_ident_word2,
  input  logic [khpg_pkg::WORD_W-1:0]     in_ident_word3,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [khpg_pkg::GROUP_W-1:0]    out_peer_group
);

  localparam int unsigned NS = khpg_pkg::NUM_STAGES;

  khpg_pkg::key_t       key;
  logic                 st_valid [0:NS];
  logic                 st_ready [0:NS];
  khpg_pkg::sip_state_t st_v     [0:NS];
  khpg_pkg::msg_t       st_msg   [0:NS];

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [khpg_pkg::GROUP_W-1:0]  group_r;
  logic [khpg_pkg::WORD_W-1:0]   fold;

  khpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign st_valid[0] = in_valid;
  assign st_v[0]     = khpg_pkg::init_state(key);
  assign st_msg[0]   = {in_ident_word3, in_ident_word2, in_ident_word1, in_ident_word0};
  assign in_stall    = !st_ready[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    khpg_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (khpg_pkg::stage_ctl(i)),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .in_v      (st_v[i]),
      .in_msg    (st_msg[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .out_v     (st_v[i+1]),
      .out_msg   (st_msg[i+1])
    );
  end

  assign st_ready[NS]  = !out_valid_r || !out_stall;
  assign out_valid_nxt = st_ready[NS] ? st_valid[NS] : out_valid_r;
  assign fold          = st_v[NS][0] ^ st_v[NS][1] ^ st_v[NS][2] ^ st_v[NS][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[NS] && st_valid[NS]) begin
      group_r <= fold[khpg_pkg::GROUP_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peer_group = group_r;

endmodule
